FILE: sv/lbbs_pkg.sv
// lbbs_pkg: shared types and constants for the label bounding box stats unit.
// Request/result payload structs, request codes, field widths, volume pipe tag.
// No dependencies.
`timescale 1ns / 1ps

package lbbs_pkg;

  localparam int LABEL_W = 8;
  localparam int COORD_W = 12;
  localparam int CNT_W   = 37;
  localparam int TOT_W   = 45;

  localparam int LABEL_COUNT_DEF = 256;
  localparam int COORD_BITS_DEF  = 12;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

  // request codes
  localparam logic [1:0] REQ_ACC = 2'd0;
  localparam logic [1:0] REQ_CLR = 2'd1;
  localparam logic [1:0] REQ_QRY = 2'd2;
  localparam logic [1:0] REQ_TOT = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [LABEL_W-1:0] voxel_label;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] pos_z;
  } req_item_t;

  typedef struct packed {
    logic               present;
    logic [CNT_W-1:0]   voxel_count;
    logic [COORD_W-1:0] box_min_x;
    logic [COORD_W-1:0] box_min_y;
    logic [COORD_W-1:0] box_min_z;
    logic [COORD_W-1:0] box_max_x;
    logic [COORD_W-1:0] box_max_y;
    logic [COORD_W-1:0] box_max_z;
    logic [CNT_W-1:0]   box_volume;
    logic [TOT_W-1:0]   total_volume;
  } res_item_t;

  // control that rides along the box volume pipe
  typedef struct packed {
    logic valid;
    logic last;
    logic qry;
    logic present;
  } vol_tag_t;

endpackage

FILE: sv/label_bounding_box_stats_unit.sv
// label_bounding_box_stats_unit: per-label voxel count and bounding box store.
// Accumulate and clear: one transfer per cycle while no query or total is in flight,
// written back from stage 1 in the cycle after the transfer. Query: stage 1, then volume
// pipe stages A and B, then the output register. Total: walks labels 1..DEPTH-1, one memory
// read per cycle, summing box volumes. A result stalled in the output register holds the port.
// Sync reset empties the store at once (per-entry valid flops); memories are not reset.
`timescale 1ns / 1ps

module label_bounding_box_stats_unit #(
  parameter int LABEL_COUNT = lbbs_pkg::LABEL_COUNT_DEF,
  parameter int COORD_BITS  = lbbs_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  lbbs_pkg::req_item_t req,
  output logic                res_valid,
  input  logic                res_ready,
  output lbbs_pkg::res_item_t res
);

  // Only the label and coordinate bits the port carries can ever be used.
  localparam int CW    = (COORD_BITS < lbbs_pkg::COORD_W) ? COORD_BITS : lbbs_pkg::COORD_W;
  localparam int DEPTH = (LABEL_COUNT < (2 ** lbbs_pkg::LABEL_W)) ? LABEL_COUNT
                                                                  : (2 ** lbbs_pkg::LABEL_W);
  localparam int AW    = $clog2(DEPTH);
  localparam int CNTW  = lbbs_pkg::CNT_W;
  localparam int TOTW  = lbbs_pkg::TOT_W;
  localparam int EW    = CNTW + 6 * CW;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // control states
  localparam logic [1:0] ST_RUN   = 2'd0;  // streaming accumulate/clear
  localparam logic [1:0] ST_WALK  = 2'd1;  // reading every label for a total
  localparam logic [1:0] ST_DRAIN = 2'd2;  // waiting for the volume pipe / output

  logic [1:0] state;

  // Entry memory: {count, min zyx, max zyx}, one read and one write port.
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic [DEPTH-1:0] valid_bits;  // entry holds data since last clear

  // stage 1: memory data is back
  logic            s1_valid;
  logic [1:0]      s1_req;
  logic            s1_lbl_ok;
  logic [AW-1:0]   s1_addr;
  logic [3*CW-1:0] s1_pos;

  // last write, forwarded to a back-to-back access of the same label
  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  logic [EW-1:0] fwd_data;

  logic [EW-1:0]   ent;
  logic            ent_valid;
  logic [CNTW-1:0] ent_count;
  logic [3*CW-1:0] ent_min;
  logic [3*CW-1:0] ent_max;
  logic [CNTW-1:0] new_count;
  logic [3*CW-1:0] new_min;
  logic [3*CW-1:0] new_max;
  logic [EW-1:0]   wr_data;
  logic            wr_en;

  logic accept;
  logic s1_qry;
  logic s1_tot;

  // total walk
  logic [AW-1:0]   walk_addr;
  logic            w_pend;
  logic            w_last;
  logic            w_present;
  logic [TOTW-1:0] tot;
  logic [TOTW:0]   sum;
  logic [TOTW-1:0] tot_sat;

  // held query answer
  logic            q_present;
  logic [CNTW-1:0] q_count;
  logic [3*CW-1:0] q_min;
  logic [3*CW-1:0] q_max;

  lbbs_pkg::vol_tag_t  vp_in_tag;
  lbbs_pkg::vol_tag_t  vp_out_tag;
  logic [3*CW-1:0]     vp_in_min;
  logic [3*CW-1:0]     vp_in_max;
  logic [CNTW-1:0]     vp_out_vol;
  logic                hold;
  logic                emit;
  lbbs_pkg::res_item_t res_next;

  assign accept = req_valid && req_ready;
  assign s1_qry = s1_valid && (s1_req == lbbs_pkg::REQ_QRY);
  assign s1_tot = s1_valid && (s1_req == lbbs_pkg::REQ_TOT);

  // Query and total own the volume pipe and the output, so take one at a time.
  assign req_ready = (state == ST_RUN) && !s1_qry && !s1_tot;

  //--------------------------------------------------------------------------
  // Stage 1 capture
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req    <= req.req_type;
      s1_addr   <= req.voxel_label[AW-1:0];
      s1_lbl_ok <= (req.voxel_label != '0) && (32'(req.voxel_label) < LABEL_COUNT);
      s1_pos    <= {req.pos_z[CW-1:0], req.pos_y[CW-1:0], req.pos_x[CW-1:0]};
    end
  end

  //--------------------------------------------------------------------------
  // Memory: read issued at the transfer (or by the walk), write-back in stage 1
  //--------------------------------------------------------------------------
  assign rd_addr = (state == ST_WALK) ? walk_addr : req.voxel_label[AW-1:0];

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[s1_addr] <= wr_data;
    end
  end

  // Read returns old data when the previous cycle wrote the same entry.
  assign ent       = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_data : rd_data;
  assign ent_valid = s1_lbl_ok && valid_bits[s1_addr];
  assign ent_count = ent[EW-1 -: CNTW];
  assign ent_min   = ent[6*CW-1 -: 3*CW];
  assign ent_max   = ent[3*CW-1:0];

  // read-modify-write of one voxel
  always_comb begin
    if (!ent_valid) begin
      new_count = CNTW'(1);
      new_min   = s1_pos;
      new_max   = s1_pos;
    end else begin
      new_count = (ent_count == lbbs_pkg::CNT_MAX) ? ent_count : ent_count + CNTW'(1);
      for (int d = 0; d < 3; d++) begin
        new_min[d*CW +: CW] = (s1_pos[d*CW +: CW] < ent_min[d*CW +: CW]) ?
                              s1_pos[d*CW +: CW] : ent_min[d*CW +: CW];
        new_max[d*CW +: CW] = (s1_pos[d*CW +: CW] > ent_max[d*CW +: CW]) ?
                              s1_pos[d*CW +: CW] : ent_max[d*CW +: CW];
      end
    end
  end

  assign wr_data = {new_count, new_min, new_max};
  assign wr_en   = s1_valid && (s1_req == lbbs_pkg::REQ_ACC) && s1_lbl_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= s1_addr;
    fwd_data <= wr_data;
  end

  // A clear only drops the valid flags; stale data is never read again.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (s1_valid && (s1_req == lbbs_pkg::REQ_CLR)) begin
      valid_bits <= '0;
    end else if (wr_en) begin
      valid_bits[s1_addr] <= 1'b1;
    end
  end

  //--------------------------------------------------------------------------
  // Control: streaming, total walk, drain
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_RUN;
      w_pend <= 1'b0;
    end else begin
      w_pend <= 1'b0;
      unique case (state)
        ST_RUN: begin
          if (s1_tot) begin
            state <= ST_WALK;
          end else if (s1_qry) begin
            state <= ST_DRAIN;
          end
        end
        ST_WALK: begin
          w_pend <= 1'b1;
          if (walk_addr == LAST_ADDR) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (emit) begin
            state <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  // Walk starts at label 1; label 0 is background.
  always_ff @(posedge clk) begin
    if (state == ST_RUN) begin
      walk_addr <= AW'(1);
    end else if (state == ST_WALK) begin
      walk_addr <= walk_addr + AW'(1);
    end
    w_last    <= (walk_addr == LAST_ADDR);
    w_present <= valid_bits[walk_addr];
  end

  assign sum     = {1'b0, tot} + (TOTW + 1)'(vp_out_vol);
  assign tot_sat = (sum > (TOTW + 1)'(lbbs_pkg::TOT_MAX)) ? lbbs_pkg::TOT_MAX : sum[TOTW-1:0];

  // running total; the last label is folded in as the result leaves
  always_ff @(posedge clk) begin
    if (state == ST_RUN) begin
      tot <= '0;
    end else if (vp_out_tag.valid && !vp_out_tag.qry && !vp_out_tag.last) begin
      tot <= tot_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_qry) begin
      q_present <= ent_valid;
      q_count   <= ent_count;
      q_min     <= ent_min;
      q_max     <= ent_max;
    end
  end

  //--------------------------------------------------------------------------
  // Volume pipe: fed by a query in stage 1 or by walk read data
  //--------------------------------------------------------------------------
  always_comb begin
    vp_in_tag.valid   = s1_qry || w_pend;
    vp_in_tag.qry     = s1_qry;
    vp_in_tag.last    = s1_qry ? 1'b1 : w_last;
    vp_in_tag.present = s1_qry ? ent_valid : w_present;
    vp_in_min         = s1_qry ? ent_min : rd_data[6*CW-1 -: 3*CW];
    vp_in_max         = s1_qry ? ent_max : rd_data[3*CW-1:0];
  end

  lbbs_vol_pipe #(
    .CW(CW)
  ) u_vol (
    .clk     (clk),
    .rst     (rst),
    .hold    (hold),
    .in_tag  (vp_in_tag),
    .in_min  (vp_in_min),
    .in_max  (vp_in_max),
    .out_tag (vp_out_tag),
    .out_vol (vp_out_vol)
  );

  // Only the final element needs the output register; it waits there if full.
  assign hold = vp_out_tag.valid && vp_out_tag.last && res_valid && !res_ready;
  assign emit = vp_out_tag.valid && vp_out_tag.last && !hold;

  always_comb begin
    res_next = '0;
    if (vp_out_tag.qry) begin
      if (q_present) begin
        res_next.present     = 1'b1;
        res_next.voxel_count = q_count;
        res_next.box_min_x   = lbbs_pkg::COORD_W'(q_min[0 +: CW]);
        res_next.box_min_y   = lbbs_pkg::COORD_W'(q_min[CW +: CW]);
        res_next.box_min_z   = lbbs_pkg::COORD_W'(q_min[2*CW +: CW]);
        res_next.box_max_x   = lbbs_pkg::COORD_W'(q_max[0 +: CW]);
        res_next.box_max_y   = lbbs_pkg::COORD_W'(q_max[CW +: CW]);
        res_next.box_max_z   = lbbs_pkg::COORD_W'(q_max[2*CW +: CW]);
        res_next.box_volume  = vp_out_vol;
      end
    end else begin
      res_next.total_volume = tot_sat;
    end
  end

  //--------------------------------------------------------------------------
  // Output register
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= res_next;
    end
  end

endmodule

FILE: sv/lbbs_vol_pipe.sv
// lbbs_vol_pipe: two-stage box volume pipe, (max-min+1) product over x, y, z.
// Saturates to the count width, zero for an absent label. Uses lbbs_pkg.
`timescale 1ns / 1ps

module lbbs_vol_pipe #(
  parameter int CW = lbbs_pkg::COORD_W
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       hold,
  input  lbbs_pkg::vol_tag_t         in_tag,
  input  logic [3*CW-1:0]            in_min,
  input  logic [3*CW-1:0]            in_max,
  output lbbs_pkg::vol_tag_t         out_tag,
  output logic [lbbs_pkg::CNT_W-1:0] out_vol
);

  localparam int XW = CW + 1;
  localparam int QW = 2 * XW;
  localparam int PW = 3 * XW;

  logic [XW-1:0] ext [3];
  lbbs_pkg::vol_tag_t a_tag;
  lbbs_pkg::vol_tag_t b_tag;
  logic [QW-1:0] a_pxy;
  logic [XW-1:0] a_ez;
  logic [PW-1:0] b_prod;

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      ext[d] = XW'(in_max[d*CW +: CW]) - XW'(in_min[d*CW +: CW]) + XW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag <= '0;
      b_tag <= '0;
    end else if (!hold) begin
      a_tag <= in_tag;
      b_tag <= a_tag;
    end
  end

  // stage A: x*y, stage B: times z
  always_ff @(posedge clk) begin
    if (!hold) begin
      a_pxy  <= QW'(ext[0]) * QW'(ext[1]);
      a_ez   <= ext[2];
      b_prod <= PW'(a_pxy) * PW'(a_ez);
    end
  end

  assign out_tag = b_tag;

  always_comb begin
    if (!b_tag.present) begin
      out_vol = '0;
    end else if (64'(b_prod) > 64'(lbbs_pkg::CNT_MAX)) begin
      out_vol = lbbs_pkg::CNT_MAX;
    end else begin
      out_vol = lbbs_pkg::CNT_W'(b_prod);
    end
  end

endmodule

FILE: sv/lbbs_checker.sv
// lbbs_checker: port-level checks for label_bounding_box_stats_unit, bound to the top.
// Uses lbbs_pkg.
`timescale 1ns / 1ps

module lbbs_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input lbbs_pkg::req_item_t req,
  input logic                res_valid,
  input logic                res_ready,
  input lbbs_pkg::res_item_t res
);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // an absent label or a total carries no count, box maximum or box volume
  a_absent: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.present |->
      res.voxel_count == '0 && res.box_volume == '0 &&
      res.box_max_x == '0 && res.box_max_y == '0 && res.box_max_z == '0)
    else $error("absent result has nonzero fields");

  // a present label has a proper box and no total
  a_present: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.present |->
      res.voxel_count != '0 && res.box_volume != '0 && res.total_volume == '0 &&
      res.box_min_x <= res.box_max_x && res.box_min_y <= res.box_max_y &&
      res.box_min_z <= res.box_max_z)
    else $error("present result is inconsistent");

  // a query or total transfer closes the request port the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready &&
      (req.req_type == lbbs_pkg::REQ_QRY || req.req_type == lbbs_pkg::REQ_TOT)
      |=> !req_ready)
    else $error("request taken while a query or total is in flight");

endmodule

bind label_bounding_box_stats_unit lbbs_checker u_lbbs_checker (.*);

FILE: tb/label_bounding_box_stats_unit_tb.sv
// label_bounding_box_stats_unit_tb: self-checking bench for the per-label voxel count and
// bounding box unit. Needs lbbs_pkg, label_bounding_box_stats_unit and lbbs_vol_pipe; reads no files.
`timescale 1ns / 1ps

module label_bounding_box_stats_unit_tb;

  localparam int NUM_LABELS  = lbbs_pkg::LABEL_COUNT_DEF;
  localparam int REQ_BITS    = $bits(lbbs_pkg::req_item_t);
  // Slowest legal run: ~450 transfers, each a total walk, plus stalls.
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;  // long receiver hold-off for the back-pressure burst
  localparam int PHASE_ITEMS = 96;
  localparam int BURST_ITEMS = 40;
  localparam int TAIL_CYCLES = 20;   // catch stray results after the last expected one

  // one row of the directed table; want is used only where typed is set
  typedef struct packed {
    lbbs_pkg::req_item_t item;
    logic                typed;
    lbbs_pkg::res_item_t want;
  } dir_row_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_ready;
  lbbs_pkg::req_item_t req       = '0;
  logic                res_valid;
  logic                res_ready = 1'b0;
  lbbs_pkg::res_item_t res;

  always #4 clk = ~clk;

  label_bounding_box_stats_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the label store. Tallies start at zero; the box corners are
  // only ever read while the label's tally is nonzero, so they need no reset.
  // ---------------------------------------------------------------------------
  logic [lbbs_pkg::CNT_W-1:0]   vox_tally [NUM_LABELS] = '{default: '0};
  logic [lbbs_pkg::COORD_W-1:0] box_lo    [NUM_LABELS][3];
  logic [lbbs_pkg::COORD_W-1:0] box_hi    [NUM_LABELS][3];

  lbbs_pkg::res_item_t pending_stats [$];  // expected query/total results, oldest first
  lbbs_pkg::res_item_t oldest_stats;
  int        fail_cnt       = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        hold_req       = 0;  // bumped by the stimulus to ask for a long hold-off
  int        hold_seen      = 0;
  int        hold_left      = 0;
  int        hot_labels [6];

  // Box volume of one label; absent and background labels count zero.
  function automatic logic [lbbs_pkg::CNT_W-1:0] box_volume(int lab);
    logic [63:0] vol;
    int          d;
    vol = 64'd1;
    if (lab == 0 || vox_tally[lab] == '0) return '0;
    for (d = 0; d < 3; d++)
      vol = vol * (64'(box_hi[lab][d]) - 64'(box_lo[lab][d]) + 64'd1);
    return (vol > 64'(lbbs_pkg::CNT_MAX)) ? lbbs_pkg::CNT_MAX : vol[lbbs_pkg::CNT_W-1:0];
  endfunction

  // Applies one accepted request to the shadow store. Returns 1 and the expected
  // result for query and total requests, 0 for accumulate and clear.
  function automatic bit stats_step(input lbbs_pkg::req_item_t it,
                                    output lbbs_pkg::res_item_t stats);
    logic [lbbs_pkg::COORD_W-1:0] pos [3];
    logic [lbbs_pkg::TOT_W:0]     tot;
    int                           lab;
    int                           d;
    int                           l;
    pos[0] = it.pos_x;
    pos[1] = it.pos_y;
    pos[2] = it.pos_z;
    lab    = int'(it.voxel_label);
    stats  = '0;
    case (it.req_type)
      lbbs_pkg::REQ_ACC: begin
        if (lab != 0 && lab < NUM_LABELS) begin
          // first voxel of a label seeds both corners
          for (d = 0; d < 3; d++) begin
            if (vox_tally[lab] == '0 || pos[d] < box_lo[lab][d]) box_lo[lab][d] = pos[d];
            if (vox_tally[lab] == '0 || pos[d] > box_hi[lab][d]) box_hi[lab][d] = pos[d];
          end
          if (vox_tally[lab] != lbbs_pkg::CNT_MAX)
            vox_tally[lab] = vox_tally[lab] + lbbs_pkg::CNT_W'(1);
        end
        return 1'b0;
      end
      lbbs_pkg::REQ_CLR: begin
        for (l = 0; l < NUM_LABELS; l++) vox_tally[l] = '0;
        return 1'b0;
      end
      lbbs_pkg::REQ_QRY: begin
        if (lab != 0 && lab < NUM_LABELS && vox_tally[lab] != '0) begin
          stats.present     = 1'b1;
          stats.voxel_count = vox_tally[lab];
          stats.box_min_x   = box_lo[lab][0];
          stats.box_min_y   = box_lo[lab][1];
          stats.box_min_z   = box_lo[lab][2];
          stats.box_max_x   = box_hi[lab][0];
          stats.box_max_y   = box_hi[lab][1];
          stats.box_max_z   = box_hi[lab][2];
          stats.box_volume  = box_volume(lab);
        end
        return 1'b1;
      end
      default: begin  // total request
        tot = '0;
        for (l = 1; l < NUM_LABELS; l++) begin
          tot = tot + (lbbs_pkg::TOT_W + 1)'(box_volume(l));
          if (tot > (lbbs_pkg::TOT_W + 1)'(lbbs_pkg::TOT_MAX))
            tot = (lbbs_pkg::TOT_W + 1)'(lbbs_pkg::TOT_MAX);
        end
        stats.total_volume = tot[lbbs_pkg::TOT_W-1:0];
        return 1'b1;
      end
    endcase
  endfunction

  // Coordinates lean on the corners of the range so boxes hit their extremes.
  function automatic logic [lbbs_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return lbbs_pkg::COORD_W'($urandom_range(15));
      default: return lbbs_pkg::COORD_W'($urandom);
    endcase
  endfunction

  // Mostly voxels and queries on a few busy labels, so boxes and tallies grow;
  // the rest are stray labels, totals and the odd frame clear.
  function automatic lbbs_pkg::req_item_t rand_item();
    lbbs_pkg::req_item_t it;
    int                  r;
    r              = $urandom_range(999);
    it.req_type    = (r < 620) ? lbbs_pkg::REQ_ACC :
                     (r < 900) ? lbbs_pkg::REQ_QRY :
                     (r < 980) ? lbbs_pkg::REQ_TOT : lbbs_pkg::REQ_CLR;
    it.voxel_label = ($urandom_range(9) < 8) ?
                     lbbs_pkg::LABEL_W'(hot_labels[$urandom_range(5)]) :
                     lbbs_pkg::LABEL_W'($urandom_range(255));
    it.pos_x       = rand_coord();
    it.pos_y       = rand_coord();
    it.pos_z       = rand_coord();
    return it;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Offers one request, possibly after an idle gap, and records the expected
  // result at the edge where the transfer happens.
  task automatic offer(input lbbs_pkg::req_item_t it, input bit typed,
                       input lbbs_pkg::res_item_t want);
    lbbs_pkg::res_item_t pred;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      req       <= lbbs_pkg::req_item_t'(REQ_BITS'({$urandom, $urandom}));  // junk
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req       <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    if (stats_step(it, pred)) pending_stats.push_back(typed ? want : pred);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls at the current rate, and a long hold-off whenever
  // the stimulus asks for one. The hold-off is counted here, not by the sender.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every result transfer is matched against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (pending_stats.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_cnt++;
      end else begin
        oldest_stats = pending_stats.pop_front();
        check_field("present",      64'(oldest_stats.present),      64'(res.present));
        check_field("voxel_count",  64'(oldest_stats.voxel_count),  64'(res.voxel_count));
        check_field("box_min_x",    64'(oldest_stats.box_min_x),    64'(res.box_min_x));
        check_field("box_min_y",    64'(oldest_stats.box_min_y),    64'(res.box_min_y));
        check_field("box_min_z",    64'(oldest_stats.box_min_z),    64'(res.box_min_z));
        check_field("box_max_x",    64'(oldest_stats.box_max_x),    64'(res.box_max_x));
        check_field("box_max_y",    64'(oldest_stats.box_max_y),    64'(res.box_max_y));
        check_field("box_max_z",    64'(oldest_stats.box_max_z),    64'(res.box_max_z));
        check_field("box_volume",   64'(oldest_stats.box_volume),   64'(res.box_volume));
        check_field("total_volume", 64'(oldest_stats.total_volume), 64'(res.total_volume));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("label_bounding_box_stats_unit_tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t rows [$];
    int       phase;
    int       n;
    int       k;

    // Directed table. Typed results are the ones that follow from the request
    // alone: an empty store, the full-range box, a single-voxel box, totals.
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_QRY, 8'd1, 12'd0, 12'd0, 12'd0},
                     1'b1, '0});
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_QRY, 8'd0,
                                           12'hFFF, 12'hFFF, 12'hFFF}, 1'b1, '0});
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_QRY, 8'd255, 12'd0, 12'd0, 12'd0},
                     1'b1, '0});
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_TOT, 8'd0, 12'd0, 12'd0, 12'd0},
                     1'b1, '0});
    // background voxels never count
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_ACC, 8'd0,
                                           12'hFFF, 12'hFFF, 12'hFFF}, 1'b0, '0});
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_QRY, 8'd0, 12'd0, 12'd0, 12'd0},
                     1'b1, '0});
    // opposite corners of the volume: largest possible box
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_ACC, 8'd1, 12'd0, 12'd0, 12'd0},
                     1'b0, '0});
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_ACC, 8'd1,
                                           12'hFFF, 12'hFFF, 12'hFFF}, 1'b0, '0});
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_QRY, 8'd1, 12'd0, 12'd0, 12'd0},
                     1'b1,
                     lbbs_pkg::res_item_t'{1'b1, 37'd2, 12'd0, 12'd0, 12'd0,
                                           12'hFFF, 12'hFFF, 12'hFFF,
                                           37'h10_0000_0000, 45'd0}});
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_ACC, 8'd255, 12'd7, 12'd9, 12'd11},
                     1'b0, '0});
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_QRY, 8'd255, 12'd0, 12'd0, 12'd0},
                     1'b1,
                     lbbs_pkg::res_item_t'{1'b1, 37'd1, 12'd7, 12'd9, 12'd11,
                                           12'd7, 12'd9, 12'd11, 37'd1, 45'd0}});
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_TOT, 8'd0, 12'd0, 12'd0, 12'd0},
                     1'b1,
                     lbbs_pkg::res_item_t'{total_volume: 45'h10_0000_0001, default: '0}});
    // box that widens on every axis with each voxel
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_ACC, 8'd2,
                                           12'd100, 12'd200, 12'd300}, 1'b0, '0});
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_ACC, 8'd2,
                                           12'd50, 12'd250, 12'd299}, 1'b0, '0});
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_ACC, 8'd2,
                                           12'd120, 12'd180, 12'd310}, 1'b0, '0});
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_QRY, 8'd2, 12'd0, 12'd0, 12'd0},
                     1'b0, '0});
    // frame clear empties every label
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_CLR, 8'd0, 12'd0, 12'd0, 12'd0},
                     1'b0, '0});
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_QRY, 8'd1, 12'd0, 12'd0, 12'd0},
                     1'b1, '0});
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_TOT, 8'd0, 12'd0, 12'd0, 12'd0},
                     1'b1, '0});
    // first voxel after a clear must reseed the old box
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_ACC, 8'd1, 12'd5, 12'd6, 12'd7},
                     1'b0, '0});
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_QRY, 8'd1, 12'd0, 12'd0, 12'd0},
                     1'b0, '0});
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_ACC, 8'd128,
                                           12'hAAA, 12'h555, 12'hAAA}, 1'b0, '0});
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_ACC, 8'd128,
                                           12'h555, 12'hAAA, 12'h555}, 1'b0, '0});
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_QRY, 8'd128, 12'd0, 12'd0, 12'd0},
                     1'b0, '0});
    rows.push_back('{lbbs_pkg::req_item_t'{lbbs_pkg::REQ_TOT, 8'd0, 12'd0, 12'd0, 12'd0},
                     1'b0, '0});

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) offer(rows[i].item, rows[i].typed, rows[i].want);

    // Random phases: free flow, idle sender, stalling receiver, both.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1:       begin send_idle_pct = 55; recv_stall_pct <= 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct <= 55; end
        default: begin send_idle_pct = 23; recv_stall_pct <= 23; end
      endcase
      // a fresh set of busy labels; one phase mixes in background voxels
      for (k = 0; k < 6; k++) hot_labels[k] = $urandom_range(1, 255);
      if (phase == 1) hot_labels[0] = 0;
      if (phase == 3) hot_labels[1] = 255;
      for (n = 0; n < PHASE_ITEMS; n++) offer(rand_item(), 1'b0, '0);
    end

    // Back-pressure burst: the receiver goes quiet for a long stretch while the
    // sender keeps offering mostly queries, so the unit fills and holds off its input.
    send_idle_pct = 0;
    recv_stall_pct <= 10;
    hold_req <= hold_req + 1;
    for (n = 0; n < BURST_ITEMS; n++)
      offer(($urandom_range(3) == 0) ? rand_item()
                                     : lbbs_pkg::req_item_t'{lbbs_pkg::REQ_QRY,
                                           lbbs_pkg::LABEL_W'(hot_labels[n % 6]),
                                           rand_coord(), rand_coord(), rand_coord()},
            1'b0, '0);
    req_valid <= 1'b0;

    while (pending_stats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_cnt == 0)
      $display("label_bounding_box_stats_unit_tb: PASS");
    else
      $display("label_bounding_box_stats_unit_tb: FAIL");
    $finish;
  end

endmodule
